// ----- hw/rtl/arst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arst_pkg
// Shared types and constants of the address range segment table.
// ----------------------------------------------------------------------------
package arst_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int LINK_W       = IDX_W + 1;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_SEGMENTS);

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_OVERLAP   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic REG_LOW_BOUND  = 1'b0;
  localparam logic REG_HIGH_BOUND = 1'b1;

  typedef struct packed {
    logic [31:0]       start;
    logic [31:0]       length;
    logic [2:0]        prot;
    logic [LINK_W-1:0] next;
  } seg_rec_t;

  typedef struct packed {
    logic             alloc;
    logic             free_en;
    logic [IDX_W-1:0] idx;
  } pool_req_t;

  typedef struct packed {
    logic             full;
    logic [IDX_W-1:0] idx;
  } pool_stat_t;

endpackage

// ----- hw/rtl/arst_free_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arst_free_pool
// Slot allocator: a stack of released slots over a high-water mark.
// ----------------------------------------------------------------------------
module arst_free_pool (
  input  logic                 clk,
  input  logic                 rst,
  input  arst_pkg::pool_req_t  req,
  output arst_pkg::pool_stat_t stat
);

  logic [arst_pkg::IDX_W-1:0]  free_mem [arst_pkg::MAX_SEGMENTS];
  logic [arst_pkg::LINK_W-1:0] sp;
  logic [arst_pkg::LINK_W-1:0] hwm;
  logic [arst_pkg::LINK_W-1:0] sp_dec;
  logic [arst_pkg::IDX_W-1:0]  pop_data;
  logic [arst_pkg::IDX_W-1:0]  hold_idx;
  logic                        use_stack;

  assign sp_dec    = sp - arst_pkg::LINK_W'(1);
  assign stat.full = (sp == '0) && (hwm == arst_pkg::END_MARK);
  assign stat.idx  = use_stack ? pop_data : hold_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp  <= '0;
      hwm <= '0;
    end else if (req.alloc) begin
      if (sp != '0) begin
        sp <= sp_dec;
      end else begin
        hwm <= hwm + arst_pkg::LINK_W'(1);
      end
    end else if (req.free_en) begin
      sp <= sp + arst_pkg::LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.free_en) begin
      free_mem[sp[arst_pkg::IDX_W-1:0]] <= req.idx;
    end
    if (req.alloc) begin
      use_stack <= (sp != '0);
      pop_data  <= free_mem[sp_dec[arst_pkg::IDX_W-1:0]];
      hold_idx  <= hwm[arst_pkg::IDX_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/address_range_segment_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_segment_table
// Address-sorted linked table of used ranges with add, remove and first-fit
// find. Entries live in one synchronous memory walked one entry at a time.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    mode, range_start, range_length,
//                                             protection
// out       output     out_valid / out_ready  found_address, status
// cfg       input      cfg_write              cfg_index, cfg_data
//
// One request at a time: each visited entry takes a read and an evaluate
// state; a split adds S_ALLOC, S_SPL1 and S_SPL2, a new entry is linked
// through S_ALLOC, S_ADD1 and S_ADD2, and S_DONE posts the result. The memory read latency sets the pace.
// Synchronous reset empties the table at once; no clearing pass is needed.
// A waiting result does not block the next request; a second one waits.
// ----------------------------------------------------------------------------
module address_range_segment_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] range_start,
  input  logic [31:0] range_length,
  input  logic [2:0]  protection,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] found_address,
  output logic [1:0]  status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_ALLOC = 4'd3;
  localparam logic [3:0] S_SPL1  = 4'd4;
  localparam logic [3:0] S_SPL2  = 4'd5;
  localparam logic [3:0] S_ADD1  = 4'd6;
  localparam logic [3:0] S_ADD2  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam int LW = arst_pkg::LINK_W;
  localparam int IW = arst_pkg::IDX_W;

  logic [3:0]          state;
  logic [1:0]          op;
  logic [31:0]         rs;
  logic [31:0]         rl;
  logic [2:0]          pr;
  logic [32:0]         r1;
  logic [LW-1:0]       cur_i;
  logic [LW-1:0]       prev;
  logic [LW-1:0]       head;
  arst_pkg::seg_rec_t  prev_rec;
  logic [32:0]         walk_pos;
  logic [IW-1:0]       slot;
  logic [31:0]         res_addr;
  logic [1:0]          res_stat;
  logic [31:0]         low_bound;
  logic [31:0]         high_bound;

  arst_pkg::seg_rec_t  seg_mem [arst_pkg::MAX_SEGMENTS];
  arst_pkg::seg_rec_t  d;
  logic                rd_en;
  logic [IW-1:0]       raddr;
  logic                mem_we;
  logic [IW-1:0]       waddr;
  arst_pkg::seg_rec_t  wdata;

  arst_pkg::pool_req_t  pool_req;
  arst_pkg::pool_stat_t pool_st;

  logic [32:0]         in_end;
  logic [32:0]         d_end;
  logic [32:0]         d_s;
  logic                ovl_hit;
  logic                rm_out;
  logic                rm_in;
  logic                rm_split;
  logic                rm_left;
  logic                fit;
  logic                end_fit;
  arst_pkg::seg_rec_t  tail_rec;
  arst_pkg::seg_rec_t  head_rec;
  arst_pkg::seg_rec_t  split_rec;

  arst_free_pool u_pool (
    .clk  (clk),
    .rst  (rst),
    .req  (pool_req),
    .stat (pool_st)
  );

  assign in_ready = (state == S_IDLE);
  assign in_end   = {1'b0, range_start} + {1'b0, range_length};
  assign d_s      = {1'b0, d.start};
  assign d_end    = d_s + {1'b0, d.length};
  assign ovl_hit  = (d_s < r1) && (d_end > {1'b0, rs});
  assign rm_out   = (d_end <= {1'b0, rs}) || (d_s >= r1);
  assign rm_in    = (d.start >= rs) && (d_end <= r1);
  assign rm_split = (d.start < rs) && (d_end > r1);
  assign rm_left  = (d.start < rs);
  assign fit      = (d_s >= walk_pos) && ((d_s - walk_pos) >= {1'b0, rl});
  assign end_fit  = (walk_pos <= {1'b0, high_bound}) &&
                    (({1'b0, high_bound} - walk_pos) >= {1'b0, rl});

  always_comb begin
    tail_rec        = d;
    tail_rec.length = rs - d.start;
    head_rec        = d;
    head_rec.start  = r1[31:0];
    head_rec.length = 32'(d_end - r1);
    split_rec       = head_rec;
  end

  // memory port and allocator requests
  always_comb begin
    mem_we   = 1'b0;
    waddr    = '0;
    wdata    = '0;
    rd_en    = 1'b0;
    raddr    = cur_i[IW-1:0];
    pool_req = '0;
    case (state)
      S_RD: begin
        if (cur_i != arst_pkg::END_MARK) begin
          rd_en = 1'b1;
        end else if (op == arst_pkg::MODE_ADD && !pool_st.full) begin
          pool_req.alloc = 1'b1;
        end
      end
      S_EVAL: begin
        if (op == arst_pkg::MODE_REMOVE && !rm_out) begin
          if (rm_in) begin
            pool_req.free_en = 1'b1;
            pool_req.idx     = cur_i[IW-1:0];
            if (prev != arst_pkg::END_MARK) begin
              mem_we     = 1'b1;
              waddr      = prev[IW-1:0];
              wdata      = prev_rec;
              wdata.next = d.next;
            end
          end else if (rm_split) begin
            pool_req.alloc = !pool_st.full;
          end else if (rm_left) begin
            mem_we = 1'b1;
            waddr  = cur_i[IW-1:0];
            wdata  = tail_rec;
          end else begin
            mem_we = 1'b1;
            waddr  = cur_i[IW-1:0];
            wdata  = head_rec;
          end
        end
      end
      S_SPL1: begin
        mem_we = 1'b1;
        waddr  = slot;
        wdata  = split_rec;
      end
      S_SPL2: begin
        mem_we     = 1'b1;
        waddr      = cur_i[IW-1:0];
        wdata      = tail_rec;
        wdata.next = {1'b0, slot};
      end
      S_ADD1: begin
        mem_we       = 1'b1;
        waddr        = slot;
        wdata.start  = rs;
        wdata.length = rl;
        wdata.prot   = pr;
        wdata.next   = (prev == arst_pkg::END_MARK) ? head : prev_rec.next;
      end
      S_ADD2: begin
        if (prev != arst_pkg::END_MARK) begin
          mem_we     = 1'b1;
          waddr      = prev[IW-1:0];
          wdata      = prev_rec;
          wdata.next = {1'b0, slot};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      d <= seg_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= arst_pkg::END_MARK;
      low_bound  <= 32'd4096;
      high_bound <= 32'hC000_0000;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == arst_pkg::REG_LOW_BOUND) begin
          low_bound <= cfg_data;
        end else begin
          high_bound <= cfg_data;
        end
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= mode;
            rs       <= range_start;
            rl       <= range_length;
            pr       <= protection;
            r1       <= in_end;
            cur_i    <= head;
            prev     <= arst_pkg::END_MARK;
            walk_pos <= {1'b0, low_bound};
            res_addr <= '0;
            if ((range_length == '0 && mode != arst_pkg::MODE_FIND) ||
                (mode != arst_pkg::MODE_ADD && mode != arst_pkg::MODE_REMOVE &&
                 mode != arst_pkg::MODE_FIND)) begin
              res_stat <= arst_pkg::ST_OK;
              state    <= S_DONE;
            end else if (mode == arst_pkg::MODE_ADD && (range_start < low_bound ||
                         in_end > {1'b0, high_bound})) begin
              res_stat <= arst_pkg::ST_OVERLAP;
              state    <= S_DONE;
            end else begin
              res_stat <= arst_pkg::ST_OK;
              state    <= S_RD;
            end
          end
        end
        S_RD: begin
          if (cur_i != arst_pkg::END_MARK) begin
            state <= S_EVAL;
          end else begin
            case (op)
              arst_pkg::MODE_ADD: begin
                if (pool_st.full) begin
                  res_stat <= arst_pkg::ST_FULL;
                  state    <= S_DONE;
                end else begin
                  state <= S_ALLOC;
                end
              end
              arst_pkg::MODE_FIND: begin
                if (end_fit) begin
                  res_addr <= walk_pos[31:0];
                end else begin
                  res_stat <= arst_pkg::ST_NOT_FOUND;
                end
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_EVAL: begin
          case (op)
            arst_pkg::MODE_ADD: begin
              if (ovl_hit) begin
                res_stat <= arst_pkg::ST_OVERLAP;
                state    <= S_DONE;
              end else begin
                cur_i <= d.next;
                state <= S_RD;
                if (d.start < rs) begin
                  prev     <= cur_i;
                  prev_rec <= d;
                end
              end
            end
            arst_pkg::MODE_FIND: begin
              if (fit) begin
                res_addr <= walk_pos[31:0];
                state    <= S_DONE;
              end else begin
                cur_i <= d.next;
                state <= S_RD;
                if (d_end > walk_pos) begin
                  walk_pos <= d_end;
                end
              end
            end
            default: begin
              if (rm_split) begin
                // hold cur_i; the split writes both halves first
                if (pool_st.full) begin
                  res_stat <= arst_pkg::ST_FULL;
                  state    <= S_DONE;
                end else begin
                  state <= S_ALLOC;
                end
              end else begin
                cur_i <= d.next;
                state <= S_RD;
                if (rm_out) begin
                  prev     <= cur_i;
                  prev_rec <= d;
                end else if (rm_in) begin
                  if (prev == arst_pkg::END_MARK) begin
                    head <= d.next;
                  end else begin
                    prev_rec.next <= d.next;
                  end
                end else if (rm_left) begin
                  prev     <= cur_i;
                  prev_rec <= tail_rec;
                end else begin
                  prev     <= cur_i;
                  prev_rec <= head_rec;
                end
              end
            end
          endcase
        end
        S_ALLOC: begin
          slot  <= pool_st.idx;
          state <= (op == arst_pkg::MODE_ADD) ? S_ADD1 : S_SPL1;
        end
        S_SPL1: begin
          state <= S_SPL2;
        end
        S_SPL2: begin
          prev     <= {1'b0, slot};
          prev_rec <= split_rec;
          cur_i    <= d.next;
          state    <= S_RD;
        end
        S_ADD1: begin
          state <= S_ADD2;
        end
        S_ADD2: begin
          if (prev == arst_pkg::END_MARK) begin
            head <= {1'b0, slot};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            found_address <= res_addr;
            status        <= res_stat;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_alloc_not_full: assert property (@(posedge clk) disable iff (rst)
    pool_req.alloc |-> !pool_st.full)
    else $error("slot allocated from a full table");

  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> $past(state == S_RD && cur_i != arst_pkg::END_MARK))
    else $error("entry evaluated without a read");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !rd_en)
    else $error("memory read and write in the same cycle");

  a_one_op_per_alloc: assert property (@(posedge clk) disable iff (rst)
    pool_req.alloc |=> (state == S_ALLOC))
    else $error("allocation result not consumed");
`endif

endmodule

// ----- sim/address_range_segment_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_segment_table_tb
// Drives add, remove and find requests into the segment table under several
// bound settings and idle patterns. A scoreboard keeps its own copy of the
// sorted table, predicts each result and checks the output stream in order.
// ----------------------------------------------------------------------------
module address_range_segment_table_tb;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int NSEG = 256;
  localparam int ENDM = 256;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    logic [31:0] addr;
    logic [1:0]  st;
  } seg_result_t;

  class SegmentTableScoreboard;
    logic [31:0] lo_bound = 32'd4096;
    logic [31:0] hi_bound = 32'hC000_0000;
    logic [31:0] seg_start [NSEG];
    logic [31:0] seg_len [NSEG];
    logic [2:0]  seg_prot [NSEG];
    int          seg_next [NSEG];
    bit          seg_used [NSEG];
    int          head = ENDM;
    seg_result_t pending_results[$];
    int          errors = 0;

    function new();
      for (int i = 0; i < NSEG; i++) begin
        seg_start[i] = 0; seg_len[i] = 0; seg_prot[i] = 0;
        seg_next[i] = 0; seg_used[i] = 0;
      end
    endfunction

    function longint unsigned seg_end(int i);
      return longint'(seg_start[i]) + longint'(seg_len[i]);
    endfunction

    function int free_slot();
      for (int i = 0; i < NSEG; i++)
        if (!seg_used[i]) return i;
      return ENDM;
    endfunction

    function logic [1:0] predict_add(logic [31:0] s32, logic [31:0] len, logic [2:0] prot);
      longint unsigned s, e;
      int i, prev, slot, steps;
      s = s32;
      e = longint'(s32) + longint'(len);
      if (len == 0) return arst_pkg::ST_OK;
      if (s < lo_bound || e > hi_bound) return arst_pkg::ST_OVERLAP;
      i = head;
      steps = 0;
      while (i < NSEG && steps < NSEG) begin
        if (seg_start[i] < e && seg_end(i) > s) return arst_pkg::ST_OVERLAP;
        i = seg_next[i];
        steps++;
      end
      slot = free_slot();
      if (slot >= NSEG) return arst_pkg::ST_FULL;
      prev = ENDM;
      i = head;
      steps = 0;
      while (i < NSEG && steps < NSEG) begin
        if (seg_start[i] >= s) break;
        prev = i;
        i = seg_next[i];
        steps++;
      end
      seg_start[slot] = s32;
      seg_len[slot] = len;
      seg_prot[slot] = prot;
      seg_used[slot] = 1;
      if (prev >= NSEG) begin
        seg_next[slot] = head;
        head = slot;
      end else begin
        seg_next[slot] = seg_next[prev];
        seg_next[prev] = slot;
      end
      return arst_pkg::ST_OK;
    endfunction

    function logic [1:0] predict_remove(logic [31:0] s32, logic [31:0] len);
      longint unsigned r0, r1, s, e;
      int i, prev, nxt, slot, steps;
      r0 = s32;
      r1 = longint'(s32) + longint'(len);
      if (len == 0) return arst_pkg::ST_OK;
      i = head;
      steps = 0;
      while (i < NSEG && steps < NSEG) begin
        if (seg_start[i] < r0 && seg_end(i) > r1 && free_slot() >= NSEG)
          return arst_pkg::ST_FULL;
        i = seg_next[i];
        steps++;
      end
      prev = ENDM;
      i = head;
      steps = 0;
      while (i < NSEG && steps < 2 * NSEG) begin
        s = seg_start[i];
        e = seg_end(i);
        steps++;
        nxt = seg_next[i];
        if (e <= r0 || s >= r1) begin
          prev = i;
        end else if (s >= r0 && e <= r1) begin
          if (prev >= NSEG) head = nxt;
          else seg_next[prev] = nxt;
          seg_start[i] = 0; seg_len[i] = 0; seg_prot[i] = 0;
          seg_next[i] = 0; seg_used[i] = 0;
        end else if (s < r0 && e > r1) begin
          slot = free_slot();
          if (slot >= NSEG) return arst_pkg::ST_FULL;
          seg_start[slot] = r1[31:0];
          seg_len[slot] = 32'(e - r1);
          seg_prot[slot] = seg_prot[i];
          seg_used[slot] = 1;
          seg_next[slot] = nxt;
          seg_next[i] = slot;
          seg_len[i] = 32'(r0 - s);
          prev = slot;
        end else if (s < r0) begin
          seg_len[i] = 32'(r0 - s);
          prev = i;
        end else begin
          seg_start[i] = r1[31:0];
          seg_len[i] = 32'(e - r1);
          prev = i;
        end
        i = nxt;
      end
      return arst_pkg::ST_OK;
    endfunction

    function seg_result_t predict_find(logic [31:0] len);
      seg_result_t r;
      longint unsigned cur, need, s, e, gap;
      int i, steps;
      cur = lo_bound;
      need = len;
      i = head;
      steps = 0;
      while (i < NSEG && steps < NSEG) begin
        s = seg_start[i];
        e = seg_end(i);
        gap = (s > cur) ? s - cur : 0;
        if (gap >= need && s >= cur) begin
          r.addr = cur[31:0];
          r.st = arst_pkg::ST_OK;
          return r;
        end
        if (e > cur) cur = e;
        i = seg_next[i];
        steps++;
      end
      if (cur <= hi_bound && longint'(hi_bound) - cur >= need) begin
        r.addr = cur[31:0];
        r.st = arst_pkg::ST_OK;
      end else begin
        r.addr = 0;
        r.st = arst_pkg::ST_NOT_FOUND;
      end
      return r;
    endfunction

    function void note_request(logic [1:0] m, logic [31:0] s, logic [31:0] l, logic [2:0] p);
      seg_result_t r;
      r.addr = 0;
      r.st = arst_pkg::ST_OK;
      case (m)
        arst_pkg::MODE_ADD:    r.st = predict_add(s, l, p);
        arst_pkg::MODE_REMOVE: r.st = predict_remove(s, l);
        arst_pkg::MODE_FIND:   r = predict_find(l);
        default:               ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] addr, logic [1:0] st);
      seg_result_t x;
      if (pending_results.size() == 0) begin
        $error("unexpected result: found_address %h status %0d", addr, st);
        errors++;
        return;
      end
      x = pending_results.pop_front();
      if (addr !== x.addr) begin
        $error("found_address: expected %h actual %h", x.addr, addr);
        errors++;
      end
      if (st !== x.st) begin
        $error("status: expected %0d actual %0d", x.st, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  mode = 0;
  logic [31:0] range_start = 0;
  logic [31:0] range_length = 0;
  logic [2:0]  protection = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] found_address;
  logic [1:0]  status;
  logic        cfg_write = 0;
  logic        cfg_index = 0;
  logic [31:0] cfg_data = 0;

  SegmentTableScoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  address_range_segment_table dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // sample results; count cycles in which nothing moves
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(found_address, status);
    if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] m, logic [31:0] s, logic [31:0] l, logic [2:0] p);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1;
    mode <= m;
    range_start <= s;
    range_length <= l;
    protection <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, s, l, p);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bound(logic idx, logic [31:0] val);
    drain();
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    if (idx == arst_pkg::REG_LOW_BOUND) sb.lo_bound = val;
    else sb.hi_bound = val;
  endtask

  task automatic random_request();
    logic [1:0]  m;
    logic [31:0] s, l;
    int pick;
    pick = $urandom_range(99);
    m = (pick < 45) ? arst_pkg::MODE_ADD : (pick < 70) ? arst_pkg::MODE_REMOVE :
        (pick < 95) ? arst_pkg::MODE_FIND : MODE_NOP;
    if ($urandom_range(9) == 0) begin
      s = $urandom;
      l = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(4096));
    end else begin
      s = sb.lo_bound + 32'($urandom_range(4095) * 16);
      l = 32'($urandom_range(1, 64) * 16 + (($urandom_range(3) == 0) ? $urandom_range(15) : 0));
    end
    send_request(m, s, l, 3'($urandom_range(7)));
  endtask

  // pack the table until it fills, then hit it with adds and a split
  task automatic fill_table();
    for (int k = 0; k < 270; k++)
      send_request(arst_pkg::MODE_ADD, 32'h1000_0000 + 32'(k * 64), 32'd32, 3'(k));
    send_request(arst_pkg::MODE_REMOVE, 32'h1000_0000 + 32'd8, 32'd8, 3'd0);
    send_request(arst_pkg::MODE_FIND, 32'd0, 32'd32, 3'd0);
    send_request(arst_pkg::MODE_REMOVE, 32'h1000_0000, 32'h0001_0000, 3'd0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed corner cases at reset bounds
    send_request(arst_pkg::MODE_ADD, 32'h2000, 32'd0, 3'd7);
    send_request(arst_pkg::MODE_REMOVE, 32'h2000, 32'd0, 3'd0);
    send_request(arst_pkg::MODE_ADD, 32'h0FFF, 32'h10, 3'd1);
    send_request(arst_pkg::MODE_ADD, 32'hBFFF_FFF0, 32'h10, 3'd2);
    send_request(arst_pkg::MODE_ADD, 32'hBFFF_FFF0, 32'h11, 3'd2);
    send_request(arst_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd3);
    send_request(arst_pkg::MODE_FIND, 32'hFFFF_FFFF, 32'd0, 3'd0);
    send_request(arst_pkg::MODE_ADD, 32'h1000, 32'h1000, 3'd4);
    send_request(arst_pkg::MODE_ADD, 32'h3000, 32'h1000, 3'd5);
    send_request(arst_pkg::MODE_ADD, 32'h1800, 32'h100, 3'd6);
    send_request(arst_pkg::MODE_FIND, 32'd0, 32'd0, 3'd0);
    send_request(arst_pkg::MODE_FIND, 32'd0, 32'h1000, 3'd0);
    send_request(arst_pkg::MODE_FIND, 32'd0, 32'hFFFF_FFFF, 3'd0);
    send_request(arst_pkg::MODE_REMOVE, 32'h1400, 32'h200, 3'd0);
    send_request(arst_pkg::MODE_REMOVE, 32'h0, 32'h1100, 3'd0);
    send_request(arst_pkg::MODE_REMOVE, 32'h3F00, 32'h1000, 3'd0);
    send_request(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    send_request(arst_pkg::MODE_FIND, 32'd0, 32'h800, 3'd0);
    send_request(arst_pkg::MODE_REMOVE, 32'h0, 32'hFFFF_FFFF, 3'd0);
    send_request(arst_pkg::MODE_FIND, 32'd0, 32'd1, 3'd0);

    send_idle_pct = 0; recv_stall_pct = 0;
    fill_table();
    repeat (200) random_request();

    write_bound(arst_pkg::REG_LOW_BOUND, 32'd0);
    write_bound(arst_pkg::REG_HIGH_BOUND, 32'hFFFF_FFFF);
    send_idle_pct = 84; recv_stall_pct = 0;
    send_request(arst_pkg::MODE_ADD, 32'd0, 32'h10, 3'd1);
    send_request(arst_pkg::MODE_ADD, 32'hFFFF_FFF0, 32'hF, 3'd2);
    repeat (200) random_request();

    write_bound(arst_pkg::REG_LOW_BOUND, 32'h0010_0000);
    write_bound(arst_pkg::REG_HIGH_BOUND, 32'h0020_0000);
    send_idle_pct = 0; recv_stall_pct = 84;
    repeat (200) random_request();

    // reversed bounds: adds of nonzero length overlap, finds fail unless a gap between entries fits
    write_bound(arst_pkg::REG_LOW_BOUND, 32'h8000_0000);
    write_bound(arst_pkg::REG_HIGH_BOUND, 32'h4000_0000);
    send_idle_pct = 25; recv_stall_pct = 25;
    repeat (100) random_request();

    write_bound(arst_pkg::REG_LOW_BOUND, 32'd4096);
    write_bound(arst_pkg::REG_HIGH_BOUND, 32'hC000_0000);
    repeat (70) random_request();
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (30) random_request();

    drain();
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ----- address_range_segment_table.f -----
hw/rtl/arst_pkg.sv
hw/rtl/arst_free_pool.sv
hw/rtl/address_range_segment_table.sv
sim/address_range_segment_table_tb.sv
